// ----- rtl/core/vlcp_pkg.sv -----
// Shared types and constants of the variable-length code packer.
// Used by the controller, datapath, top level and testbench; depends on nothing.
package vlcp_pkg;

   localparam int BYTE_BITS      = 8;
   localparam int CODE_W         = 16;
   localparam int LEN_W          = 5;
   localparam int INDEX_W        = 9;
   localparam int TABLE_DEPTH    = 257;
   localparam int MAX_CODE_BITS  = 16;
   localparam int LEN_LIMIT      = (MAX_CODE_BITS < CODE_W) ? MAX_CODE_BITS : CODE_W;
   // pending bits (at most 7) plus one full code fit in the window
   localparam int WIN_W          = CODE_W + BYTE_BITS;
   localparam int CNT_W          = $clog2(WIN_W + 1);

   localparam logic [INDEX_W-1:0] TERM_ENTRY = INDEX_W'(9'h100);

   typedef enum logic [1:0] {
      FUNC_LOAD   = 2'd0,
      FUNC_ENCODE = 2'd1,
      FUNC_END    = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   typedef struct packed {
      logic [LEN_W-1:0]  len;
      logic [CODE_W-1:0] code;
   } entry_type;

   typedef struct packed {
      logic load;      // write the table entry from the input word
      logic merge;     // append the looked-up code to the bit window
      logic emit;      // move the top byte of the window to the output register
      logic last;      // mark the emitted byte as the final one of the packet
      logic clear;     // empty the window for the next packet
   } cmd_type;

   typedef struct packed {
      logic cnt_ge8;
      logic cnt_eq8;
      logic cnt_zero;
      logic out_free;
   } status_type;

endpackage

// ----- rtl/core/variable_length_code_packer.sv -----
// Variable-length code packer. A load word writes one of 257 table entries (byte
// values 0..255 and the terminator at 256) with a code of up to 16 bits; an entry
// must be loaded before any word looks it up, as the table has no reset. An encode
// word shifts the code of its byte into output bytes, first code bit in bit 7, and
// an end word appends the terminator code, zero-pads the last partial byte and flags
// the final byte with rsp_last_byte. A load word is written to the table straight from
// idle. An encode or end word passes through the registered table read, a merge of the
// code into the bit window, then the emit state, which moves the bytes one at a time
// through the single output byte register and returns to idle once it sees the window
// drained. An end word whose final byte is zero-padded returns to idle as that padded
// byte leaves. A stall on rsp_ready holds the emit state; no new word is taken until idle.
// Depends on vlcp_pkg, vlcp_ctrl and vlcp_dp.
module variable_length_code_packer (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [1:0]                     req_func,
   input  logic [vlcp_pkg::INDEX_W-1:0]   req_entry_index,
   input  logic [vlcp_pkg::LEN_W-1:0]     req_code_length,
   input  logic [vlcp_pkg::CODE_W-1:0]    req_code_bits,
   input  logic [vlcp_pkg::BYTE_BITS-1:0] req_data_byte,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [vlcp_pkg::BYTE_BITS-1:0] rsp_out_byte,
   output logic                           rsp_last_byte
);
   import vlcp_pkg::*;

   cmd_type    cmd;
   status_type status;

   vlcp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_func  (req_func),
      .status    (status),
      .cmd       (cmd)
   );

   vlcp_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_func        (req_func),
      .req_entry_index (req_entry_index),
      .req_code_length (req_code_length),
      .req_code_bits   (req_code_bits),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_byte   (rsp_last_byte),
      .cmd             (cmd),
      .status          (status)
   );

endmodule

// ----- rtl/core/vlcp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Holds the code table; no package dependency.
module vlcp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/vlcp_ctrl.sv -----
// Controller of the code packer: sequences table load, lookup, merge and byte output.
// Depends on vlcp_pkg for the command and status types.
module vlcp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_func,
   input  vlcp_pkg::status_type status,
   output vlcp_pkg::cmd_type    cmd
);
   import vlcp_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MERGE,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      is_end_ff, is_end_in;
   logic      accept;
   logic      full;
   logic      pad;
   func_type  func;

   assign func      = func_type'(req_func);
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // a partial byte is padded out only by an end word
   assign full = status.cnt_ge8;
   assign pad  = is_end_ff && !status.cnt_zero && !status.cnt_ge8;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      is_end_in = is_end_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (func)
                  FUNC_LOAD: begin
                     cmd.load = 1'b1;
                  end
                  FUNC_ENCODE, FUNC_END: begin
                     is_end_in = (func == FUNC_END);
                     state_in  = ST_MERGE;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_MERGE: begin
            cmd.merge = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            cmd.emit = (full || pad) && status.out_free;
            cmd.last = is_end_ff && (pad || status.cnt_eq8);
            if (!full && !pad) begin
               cmd.clear = is_end_ff;
               state_in  = ST_IDLE;
            end else if (pad && status.out_free) begin
               cmd.clear = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         is_end_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         is_end_ff <= is_end_in;
      end
   end

endmodule

// ----- rtl/core/vlcp_dp.sv -----
// Datapath of the code packer: code table RAM, bit window and output byte register.
// Depends on vlcp_pkg and vlcp_ram.
module vlcp_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [1:0]                           req_func,
   input  logic [vlcp_pkg::INDEX_W-1:0]         req_entry_index,
   input  logic [vlcp_pkg::LEN_W-1:0]           req_code_length,
   input  logic [vlcp_pkg::CODE_W-1:0]          req_code_bits,
   input  logic [vlcp_pkg::BYTE_BITS-1:0]       req_data_byte,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [vlcp_pkg::BYTE_BITS-1:0]       rsp_out_byte,
   output logic                                 rsp_last_byte,
   input  vlcp_pkg::cmd_type                    cmd,
   output vlcp_pkg::status_type                 status
);
   import vlcp_pkg::*;

   logic [WIN_W-1:0]     win_ff, win_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [BYTE_BITS-1:0] out_byte_ff, out_byte_in;
   logic                 last_byte_ff, last_byte_in;

   entry_type            wr_entry;
   entry_type            rd_entry;
   logic [INDEX_W-1:0]   rd_addr;
   logic                 wr_en;
   logic [CODE_W-1:0]    code_rev;
   logic [CODE_W-1:0]    code_mask;
   logic [WIN_W-1:0]     code_win;

   // saturate the loaded length; drop writes beyond the terminator entry
   assign wr_entry.len  = (req_code_length > LEN_W'(LEN_LIMIT)) ? LEN_W'(LEN_LIMIT)
                                                                 : req_code_length;
   assign wr_entry.code = req_code_bits;
   assign wr_en         = cmd.load && (req_entry_index < INDEX_W'(TABLE_DEPTH));
   assign rd_addr       = (func_type'(req_func) == FUNC_END) ? TERM_ENTRY
                                                             : INDEX_W'(req_data_byte);

   vlcp_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (req_entry_index),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   // first code bit goes to the most significant free position of the window
   always_comb begin
      for (int i = 0; i < CODE_W; i++) begin
         code_rev[i] = rd_entry.code[CODE_W-1-i];
      end
   end
   assign code_mask = ~({CODE_W{1'b1}} >> rd_entry.len);
   assign code_win  = {code_rev & code_mask, {BYTE_BITS{1'b0}}} >> cnt_ff[2:0];

   assign status.cnt_ge8  = (cnt_ff >= CNT_W'(BYTE_BITS));
   assign status.cnt_eq8  = (cnt_ff == CNT_W'(BYTE_BITS));
   assign status.cnt_zero = (cnt_ff == '0);
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      win_in       = win_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      out_byte_in  = out_byte_ff;
      last_byte_in = last_byte_ff;
      if (cmd.merge) begin
         win_in = win_ff | code_win;
         cnt_in = cnt_ff + CNT_W'(rd_entry.len);
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         out_byte_in  = win_ff[WIN_W-1 -: BYTE_BITS];
         last_byte_in = cmd.last;
         win_in       = win_ff << BYTE_BITS;
         cnt_in       = cnt_ff - CNT_W'(BYTE_BITS);
      end
      if (cmd.clear) begin
         win_in = '0;
         cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         win_ff       <= win_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      out_byte_ff  <= out_byte_in;
      last_byte_ff <= last_byte_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = out_byte_ff;
   assign rsp_last_byte = last_byte_ff;

endmodule

// ----- tb/tb_variable_length_code_packer.sv -----
// Self-checking testbench of variable_length_code_packer: loads code tables, encodes
// packets and checks every packed byte against a predictor kept in the testbench.
// Depends on vlcp_pkg and the variable_length_code_packer RTL.
`timescale 1ns / 100ps

module tb_variable_length_code_packer;
   import vlcp_pkg::*;

   typedef struct {
      func_type               op;
      logic [INDEX_W-1:0]     entry;
      logic [LEN_W-1:0]       len;
      logic [CODE_W-1:0]      bits;
      logic [BYTE_BITS-1:0]   data;
      bit                     drain_first;
   } code_word_type;

   typedef struct {
      logic [BYTE_BITS-1:0] value;
      logic                 last;
   } packed_byte_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [1:0]             req_func = FUNC_LOAD;
   logic [INDEX_W-1:0]     req_entry_index = '0;
   logic [LEN_W-1:0]       req_code_length = '0;
   logic [CODE_W-1:0]      req_code_bits = '0;
   logic [BYTE_BITS-1:0]   req_data_byte = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [BYTE_BITS-1:0]   rsp_out_byte;
   logic                   rsp_last_byte;

   variable_length_code_packer i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_entry_index (req_entry_index),
      .req_code_length (req_code_length),
      .req_code_bits   (req_code_bits),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_byte   (rsp_last_byte)
   );

   // stimulus and expectations
   code_word_type    words_to_send[$];
   code_word_type    word_on_bus;
   packed_byte_type  expected_bytes[$];

   // generator view of which entries hold a code
   bit            gen_loaded[TABLE_DEPTH];
   int            byte_pool[$];

   // predictor state
   logic [LEN_W-1:0]     tbl_len[TABLE_DEPTH];
   logic [CODE_W-1:0]    tbl_code[TABLE_DEPTH];
   logic [BYTE_BITS-1:0] pend_val = '0;
   int                   pend_cnt = 0;

   int   fail_count = 0;
   int   loads_done = 0;
   int   encodes_done = 0;
   int   ends_done = 0;
   int   other_done = 0;
   int   bytes_seen = 0;
   int   send_wait = 0;
   int   recv_wait = 0;
   int   hold_left = 0;
   bit   send_burst = 1'b0;
   bit   recv_burst = 1'b0;

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #100000;
      $display("timeout: %0d bytes still awaited, %0d words unsent",
               expected_bytes.size(), words_to_send.size());
      $display("TEST FAILED");
      $finish;
   end

   task automatic report_mismatch(input string what);
      fail_count++;
      if (fail_count <= 20) begin
         $display("MISMATCH @%0t: %s", $time, what);
      end
   endtask

   // shift one table code into the pending byte, first code bit lands highest
   function automatic int shift_code(input int entry);
      int made;
      made = 0;
      for (int i = 0; i < int'(tbl_len[entry]); i++) begin
         pend_val = {pend_val[BYTE_BITS-2:0], tbl_code[entry][i]};
         pend_cnt++;
         if (pend_cnt == BYTE_BITS) begin
            expected_bytes.push_back('{pend_val, 1'b0});
            made++;
            pend_val = '0;
            pend_cnt = 0;
         end
      end
      return made;
   endfunction

   function automatic void pack_word(input code_word_type w);
      int made;
      logic [BYTE_BITS-1:0] tail;
      case (w.op)
         FUNC_LOAD: begin
            loads_done++;
            if (int'(w.entry) < TABLE_DEPTH) begin
               tbl_len[w.entry] = (int'(w.len) > LEN_LIMIT) ? LEN_W'(LEN_LIMIT) : w.len;
               tbl_code[w.entry] = w.bits;
            end
         end
         FUNC_ENCODE: begin
            encodes_done++;
            made = shift_code(int'(w.data));
         end
         FUNC_END: begin
            ends_done++;
            made = shift_code(int'(TERM_ENTRY));
            if (pend_cnt != 0) begin
               tail = pend_val << (BYTE_BITS - pend_cnt);
               expected_bytes.push_back('{tail, 1'b0});
               made++;
            end
            if (made > 0) begin
               expected_bytes[expected_bytes.size()-1].last = 1'b1;
            end
            pend_val = '0;
            pend_cnt = 0;
         end
         default: other_done++;
      endcase
   endfunction

   function automatic int pick_byte();
      if (byte_pool.size() == 0) begin
         return 0;
      end
      return byte_pool[$urandom_range(0, byte_pool.size() - 1)];
   endfunction

   function automatic void add_word(input func_type op, input int entry, input int len,
                                    input int bits, input int data, input bit drain);
      code_word_type w;
      w.op = op;
      w.entry = INDEX_W'(entry);
      w.len = LEN_W'(len);
      w.bits = CODE_W'(bits);
      w.data = BYTE_BITS'(data);
      w.drain_first = drain;
      if (op == FUNC_LOAD && entry < TABLE_DEPTH) begin
         if (entry < 256 && !gen_loaded[entry]) begin
            byte_pool.push_back(entry);
         end
         gen_loaded[entry] = 1'b1;
      end
      words_to_send.push_back(w);
   endfunction

   // sender: one word at a time, random gaps between words
   always @(posedge clock) begin : drive
      logic offer;
      if (reset) begin
         req_valid <= 1'b0;
         send_wait = 0;
      end else begin
         offer = req_valid;
         if (req_valid && req_ready) begin
            pack_word(word_on_bus);
            offer = 1'b0;
            if ($urandom_range(0, 15) == 0) begin
               send_burst = ($urandom_range(0, 2) == 0);
            end
            send_wait = send_burst ? 0 : $urandom_range(0, 12);
         end
         if (!offer) begin
            if (send_wait > 0) begin
               send_wait--;
            end else if (words_to_send.size() > 0 &&
                         !(words_to_send[0].drain_first && expected_bytes.size() > 0)) begin
               word_on_bus = words_to_send.pop_front();
               req_func        <= word_on_bus.op;
               req_entry_index <= word_on_bus.entry;
               req_code_length <= word_on_bus.len;
               req_code_bits   <= word_on_bus.bits;
               req_data_byte   <= word_on_bus.data;
               offer = 1'b1;
            end
         end
         req_valid <= offer;
      end
   end

   // receiver: check each byte, stall at random, once for a long stretch
   always @(posedge clock) begin : observe
      packed_byte_type want;
      logic take;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            bytes_seen++;
            if (expected_bytes.size() == 0) begin
               report_mismatch($sformatf("unexpected byte %02h last %0b",
                                         rsp_out_byte, rsp_last_byte));
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_out_byte !== want.value) begin
                  report_mismatch($sformatf("byte %0d: out_byte %02h, want %02h",
                                            bytes_seen, rsp_out_byte, want.value));
               end
               if (rsp_last_byte !== want.last) begin
                  report_mismatch($sformatf("byte %0d: last_byte %0b, want %0b",
                                            bytes_seen, rsp_last_byte, want.last));
               end
            end
            // hold off long enough for the block to back up into its input
            if (bytes_seen == 30) begin
               hold_left = 400;
            end
            if ($urandom_range(0, 15) == 0) begin
               recv_burst = ($urandom_range(0, 2) == 0);
            end
            recv_wait = recv_burst ? 0 : $urandom_range(0, 12);
         end
         if (hold_left > 0) begin
            hold_left--;
            take = 1'b0;
         end else if (recv_wait > 0) begin
            recv_wait--;
            take = 1'b0;
         end else begin
            take = 1'b1;
         end
         rsp_ready <= take;
      end
   end

   initial begin : stimulus
      int counted;
      int roll;
      int len;
      counted = 0;

      // directed: terminator, extremes, saturation, ignored words
      add_word(FUNC_LOAD, TERM_ENTRY, 3, 'h0005, 0, 1'b0);
      add_word(FUNC_LOAD, 'h00, 0, 'hFFFF, 0, 1'b0);
      add_word(FUNC_LOAD, 'hFF, 16, 'hFFFF, 'h00, 1'b0);
      add_word(FUNC_LOAD, 'h55, 5, 'hFFE6, 'hFF, 1'b0);
      add_word(FUNC_LOAD, 'hAA, 31, 'h8001, 'h55, 1'b0);
      add_word(FUNC_LOAD, 'h01, 17, 'h1234, 'hAA, 1'b0);
      add_word(FUNC_LOAD, 'h1FF, 4, 'h0000, 'h00, 1'b0);
      add_word(FUNC_LOAD, 'h101, 7, 'h7F00, 'h00, 1'b0);
      add_word(FUNC_NONE, 'h1FF, 31, 'hFFFF, 'hFF, 1'b0);
      add_word(FUNC_ENCODE, 'h1FF, 31, 'hFFFF, 'hFF, 1'b0);
      add_word(FUNC_ENCODE, 0, 0, 0, 'h55, 1'b0);
      add_word(FUNC_ENCODE, 0, 0, 0, 'hAA, 1'b0);
      add_word(FUNC_ENCODE, 0, 0, 0, 'h00, 1'b0);
      add_word(FUNC_END, 0, 0, 0, 'h55, 1'b0);
      add_word(FUNC_ENCODE, 0, 0, 0, 'h55, 1'b0);
      add_word(FUNC_ENCODE, 0, 0, 0, 'h55, 1'b0);
      add_word(FUNC_END, 0, 0, 0, 'h01, 1'b0);
      // terminator of length zero with nothing pending: no byte at all
      add_word(FUNC_LOAD, TERM_ENTRY, 0, 'hFFFF, 'h01, 1'b0);
      add_word(FUNC_END, 0, 0, 0, 'h01, 1'b0);
      add_word(FUNC_ENCODE, 0, 0, 0, 'h55, 1'b0);
      add_word(FUNC_END, 0, 0, 0, 'h55, 1'b0);
      // long terminator after five pending bits: three bytes from one end word
      add_word(FUNC_LOAD, TERM_ENTRY, 16, 'hC3A5, 'h55, 1'b0);
      add_word(FUNC_ENCODE, 0, 0, 0, 'h55, 1'b0);
      add_word(FUNC_ENCODE, 0, 0, 0, 'hFF, 1'b0);
      add_word(FUNC_END, 0, 0, 0, 'hFF, 1'b0);
      add_word(FUNC_ENCODE, 0, 0, 0, 'h01, 1'b1);

      // random packets, mostly encodes of loaded bytes
      while (counted < 75) begin
         roll = $urandom_range(0, 99);
         if (roll < 15) begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 31) : $urandom_range(0, 16);
            if ($urandom_range(0, 7) == 0) begin
               add_word(FUNC_LOAD, $urandom_range(257, 511), len, $urandom_range(0, 'hFFFF),
                        pick_byte(), 1'b0);
            end else begin
               add_word(FUNC_LOAD, ($urandom_range(0, 9) == 0) ? 256 : $urandom_range(0, 255),
                        len, $urandom_range(0, 'hFFFF), pick_byte(), 1'b0);
               counted++;
            end
         end else if (roll < 82) begin
            add_word(FUNC_ENCODE, $urandom_range(0, 511), $urandom_range(0, 31),
                     $urandom_range(0, 'hFFFF), pick_byte(), 1'b0);
            counted++;
         end else if (roll < 97) begin
            add_word(FUNC_END, $urandom_range(0, 511), $urandom_range(0, 31),
                     $urandom_range(0, 'hFFFF), pick_byte(), $urandom_range(0, 2) == 0);
            counted++;
         end else begin
            add_word(FUNC_NONE, $urandom_range(0, 511), $urandom_range(0, 31),
                     $urandom_range(0, 'hFFFF), pick_byte(), 1'b0);
         end
      end
      add_word(FUNC_END, 0, 0, 0, pick_byte(), 1'b0);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (words_to_send.size() > 0 || req_valid) begin
         @(posedge clock);
      end
      while (expected_bytes.size() > 0) begin
         @(posedge clock);
      end
      repeat (20) @(posedge clock);

      $display("Sent %0d loads, %0d encodes, %0d packet ends, %0d unused-function words;",
               loads_done, encodes_done, ends_done, other_done);
      $display("checked %0d packed bytes with %0d mismatches.", bytes_seen, fail_count);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
